// ===== design/sem_pkg.sv =====
// Shared widths, reset values, register indexes and types for the stereo echo mixer.
package sem_pkg;

  // Field widths of the streaming and configuration ports.
  localparam int MixW     = 21;
  localparam int SampleW  = 16;
  localparam int GainW    = 16;
  localparam int DlyLenW  = 18;
  localparam int CfgDataW = 18;
  localparam int CfgIdxW  = 2;

  // Delay line geometry.
  localparam int DelayDepth = 262144;
  localparam int AddrW      = $clog2(DelayDepth);

  typedef logic [AddrW-1:0] addr_t;

  localparam addr_t LastAddr = AddrW'(DelayDepth - 1);

  // Register reset values.
  localparam logic [DlyLenW-1:0] DelayLenReset = DlyLenW'(22048);
  localparam logic [GainW-1:0]   GainReset     = GainW'(19661);

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_ECHO_ENABLE  = 2'd0,
    CFG_DELAY_LENGTH = 2'd1,
    CFG_LEFT_GAIN    = 2'd2,
    CFG_RIGHT_GAIN   = 2'd3
  } cfg_idx_e;

  // One access to the delay line memory: a read and a write in the same cycle.
  typedef struct packed {
    logic                      rd_en;
    addr_t                     rd_addr;
    logic                      wr_en;
    addr_t                     wr_addr;
    logic signed [SampleW-1:0] wr_data;
  } ram_req_t;

endpackage

// ===== design/sem_echo_ram.sv =====
// Delay line memory with one write port and one registered read port.
module sem_echo_ram (
  input  logic                               clk_i,
  input  sem_pkg::ram_req_t                  req_i,
  output logic signed [sem_pkg::SampleW-1:0] rd_data_o
);

  logic signed [sem_pkg::SampleW-1:0] mem [sem_pkg::DelayDepth];
  logic signed [sem_pkg::SampleW-1:0] rd_q;

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_q <= mem[req_i.rd_addr];
    end
  end

  assign rd_data_o = rd_q;

endmodule

// ===== design/sem_mix_clip.sv =====
// Echo scaling, channel sum, 16-bit saturation and feedback average for one frame.
module sem_mix_clip (
  input  logic                               echo_en_i,
  input  logic signed [sem_pkg::MixW-1:0]    mix_left_i,
  input  logic signed [sem_pkg::MixW-1:0]    mix_right_i,
  input  logic signed [sem_pkg::SampleW-1:0] entry_i,
  input  logic        [sem_pkg::GainW-1:0]   left_gain_i,
  input  logic        [sem_pkg::GainW-1:0]   right_gain_i,
  output logic signed [sem_pkg::SampleW-1:0] out_left_o,
  output logic signed [sem_pkg::SampleW-1:0] out_right_o,
  output logic signed [sem_pkg::SampleW-1:0] avg_o
);

  localparam int SumW = sem_pkg::MixW + 1;

  // Entry times gain over 65536, truncated toward zero.
  function automatic logic signed [16:0] scale_gain(
    input logic signed [sem_pkg::SampleW-1:0] entry,
    input logic        [sem_pkg::GainW-1:0]   gain
  );
    logic signed [32:0] prod;
    prod = entry * $signed({1'b0, gain});
    if (prod < 0) begin
      prod = prod + 33'sd65535;
    end
    return prod[32:16];
  endfunction

  // Clip a channel sum to the signed 16-bit range.
  function automatic logic signed [sem_pkg::SampleW-1:0] sat16(
    input logic signed [SumW-1:0] v
  );
    logic signed [sem_pkg::SampleW-1:0] res;
    if (v > 22'sd32767) begin
      res = 16'sh7fff;
    end else if (v < -22'sd32768) begin
      res = 16'sh8000;
    end else begin
      res = v[sem_pkg::SampleW-1:0];
    end
    return res;
  endfunction

  logic signed [16:0]      scl_left;
  logic signed [16:0]      scl_right;
  logic signed [SumW-1:0]  sum_left;
  logic signed [SumW-1:0]  sum_right;
  logic signed [16:0]      pair_sum;
  logic signed [16:0]      pair_adj;

  // Echo contribution, zero when echo is off.
  always_comb begin
    if (echo_en_i) begin
      scl_left  = scale_gain(entry_i, left_gain_i);
      scl_right = scale_gain(entry_i, right_gain_i);
    end else begin
      scl_left  = '0;
      scl_right = '0;
    end
  end

  // Channel sums and saturation.
  assign sum_left  = {mix_left_i[sem_pkg::MixW-1], mix_left_i} +
                     {{(SumW-17){scl_left[16]}}, scl_left};
  assign sum_right = {mix_right_i[sem_pkg::MixW-1], mix_right_i} +
                     {{(SumW-17){scl_right[16]}}, scl_right};

  assign out_left_o  = sat16(sum_left);
  assign out_right_o = sat16(sum_right);

  // Average of the clipped channels, rounded toward zero.
  assign pair_sum = {out_left_o[15], out_left_o} + {out_right_o[15], out_right_o};
  assign pair_adj = pair_sum + {16'd0, pair_sum[16]};
  assign avg_o    = pair_adj[16:1];

endmodule

// ===== design/stereo_echo_mix_and_clip.sv =====
// Top level of the stereo echo mixer: configuration, frame pipeline and delay line control.
//
// The block takes one stereo frame beat per clock cycle while the output side keeps up,
// and returns each clipped frame through the compute stage and the output register. The
// cycle of acceptance issues the delay line read; the compute stage then scales the delayed
// entry, adds it, clips both channels and writes the channel average back when it advances,
// all in one pass through two 16 by 16 multipliers, the adders and the clip logic. A short
// delay whose entry is still being written by the previous frame is taken from a
// forwarding register, so any delay length runs at full rate. The delay line starts as zeros
// without a clearing pass: entries not yet written since reset read as zero, tracked
// by the write position and a wrap flag. Configuration writes are meant for idle time.
module stereo_echo_mix_and_clip (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic        [sem_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic        [sem_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [sem_pkg::MixW-1:0]     mix_left_i,
  input  logic signed [sem_pkg::MixW-1:0]     mix_right_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [sem_pkg::SampleW-1:0]  out_left_o,
  output logic signed [sem_pkg::SampleW-1:0]  out_right_o
);

  localparam int AddrW = sem_pkg::AddrW;
  localparam int CmpW  = ((sem_pkg::DlyLenW > AddrW) ? sem_pkg::DlyLenW : AddrW) + 1;

  // Configuration registers.
  logic                          echo_en_q;
  logic [sem_pkg::DlyLenW-1:0]   dly_len_q;
  logic [sem_pkg::GainW-1:0]     left_gain_q;
  logic [sem_pkg::GainW-1:0]     right_gain_q;

  // Write position and fill tracking.
  sem_pkg::addr_t                wp_q;
  logic                          wrap_q;

  // Compute stage.
  logic                               s1_valid_q;
  logic signed [sem_pkg::MixW-1:0]    s1_left_q;
  logic signed [sem_pkg::MixW-1:0]    s1_right_q;
  sem_pkg::addr_t                     s1_wp_q;
  logic                               s1_hit_q;
  logic                               s1_filled_q;
  logic signed [sem_pkg::SampleW-1:0] fwd_q;

  // Output register.
  logic                               out_valid_q;
  logic signed [sem_pkg::SampleW-1:0] out_left_q;
  logic signed [sem_pkg::SampleW-1:0] out_right_q;

  logic                               in_fire;
  logic                               advance;
  logic [CmpW-1:0]                    dly_ext;
  sem_pkg::addr_t                     dly;
  sem_pkg::addr_t                     rp;
  logic                               rd_filled;
  logic                               rd_hit;
  logic signed [sem_pkg::SampleW-1:0] rd_data;
  logic signed [sem_pkg::SampleW-1:0] entry;
  logic signed [sem_pkg::SampleW-1:0] mix_left_c;
  logic signed [sem_pkg::SampleW-1:0] mix_right_c;
  logic signed [sem_pkg::SampleW-1:0] avg;
  sem_pkg::ram_req_t                  ram_req;

  // Handshake: the compute stage moves on whenever the output register is empty or being read out.
  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;
  assign in_fire    = in_valid_i && in_ready_o;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      echo_en_q    <= 1'b0;
      dly_len_q    <= sem_pkg::DelayLenReset;
      left_gain_q  <= sem_pkg::GainReset;
      right_gain_q <= sem_pkg::GainReset;
    end else if (cfg_we_i) begin
      case (sem_pkg::cfg_idx_e'(cfg_index_i))
        sem_pkg::CFG_ECHO_ENABLE:  echo_en_q    <= cfg_data_i[0];
        sem_pkg::CFG_DELAY_LENGTH: dly_len_q    <= cfg_data_i[sem_pkg::DlyLenW-1:0];
        sem_pkg::CFG_LEFT_GAIN:    left_gain_q  <= cfg_data_i[sem_pkg::GainW-1:0];
        sem_pkg::CFG_RIGHT_GAIN:   right_gain_q <= cfg_data_i[sem_pkg::GainW-1:0];
        default: ;
      endcase
    end
  end

  // Read address: write position minus the clamped delay, wrapped into the line.
  always_comb begin
    dly_ext = CmpW'(dly_len_q);
    if (dly_ext >= CmpW'(sem_pkg::DelayDepth)) begin
      dly = sem_pkg::LastAddr;
    end else begin
      dly = dly_ext[AddrW-1:0];
    end
    if (wp_q >= dly) begin
      rp = wp_q - dly;
    end else begin
      rp = AddrW'({1'b0, wp_q} + (AddrW+1)'(sem_pkg::DelayDepth) - {1'b0, dly});
    end
  end

  // Entries below the write position, or all after a wrap, have been written.
  assign rd_filled = wrap_q || (rp < wp_q);
  // The frame in the compute stage writes this address at the same edge.
  assign rd_hit    = s1_valid_q && echo_en_q && (rp == s1_wp_q);

  // Write position advances once per frame while echo is on.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      wrap_q <= 1'b0;
    end else if (in_fire && echo_en_q) begin
      if (wp_q == sem_pkg::LastAddr) begin
        wp_q   <= '0;
        wrap_q <= 1'b1;
      end else begin
        wp_q <= wp_q + sem_pkg::addr_t'(1);
      end
    end
  end

  // Compute stage control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s1_hit_q    <= 1'b0;
      s1_filled_q <= 1'b0;
      s1_wp_q     <= '0;
    end else if (in_fire) begin
      s1_valid_q  <= 1'b1;
      s1_hit_q    <= rd_hit;
      s1_filled_q <= rd_filled;
      s1_wp_q     <= wp_q;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  // Compute stage payload and the forwarded feedback sample.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_left_q  <= mix_left_i;
      s1_right_q <= mix_right_i;
      fwd_q      <= avg;
    end
  end

  // Delay line access: read on acceptance, write back when the frame completes.
  always_comb begin
    ram_req.rd_en   = in_fire && echo_en_q;
    ram_req.rd_addr = rp;
    ram_req.wr_en   = advance && echo_en_q;
    ram_req.wr_addr = s1_wp_q;
    ram_req.wr_data = avg;
  end

  sem_echo_ram u_ram (
    .clk_i     (clk_i),
    .req_i     (ram_req),
    .rd_data_o (rd_data)
  );

  // Delayed entry: forwarded, from memory, or zero if never written.
  always_comb begin
    if (s1_hit_q) begin
      entry = fwd_q;
    end else if (s1_filled_q) begin
      entry = rd_data;
    end else begin
      entry = '0;
    end
  end

  sem_mix_clip u_mix (
    .echo_en_i    (echo_en_q),
    .mix_left_i   (s1_left_q),
    .mix_right_i  (s1_right_q),
    .entry_i      (entry),
    .left_gain_i  (left_gain_q),
    .right_gain_i (right_gain_q),
    .out_left_o   (mix_left_c),
    .out_right_o  (mix_right_c),
    .avg_o        (avg)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_left_q  <= mix_left_c;
      out_right_q <= mix_right_c;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_left_o  = out_left_q;
  assign out_right_o = out_right_q;

endmodule

// ===== verif/tb_stereo_echo_mix_and_clip.sv =====
// Self-checking testbench for the stereo echo mixer with its own echo and clip predictor.
module tb_stereo_echo_mix_and_clip;
  import sem_pkg::*;

  localparam int SampleMax     = 32767;
  localparam int SampleMin     = -32768;
  localparam int GainScale     = 65536;
  localparam int LongHold      = 400;
  localparam int WatchdogLimit = 4000;
  localparam int PrintLimit    = 100;
  localparam int RandPhases    = 12;
  localparam int PhaseFrames   = 110;

  typedef struct packed {
    logic signed [MixW-1:0] left;
    logic signed [MixW-1:0] right;
  } mix_frame_t;

  typedef struct packed {
    logic signed [SampleW-1:0] left;
    logic signed [SampleW-1:0] right;
  } out_frame_t;

  // Block inputs, all known from time zero.
  logic                       clk_i       = 1'b0;
  logic                       rst_ni      = 1'b0;
  logic                       cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]         cfg_index_i = '0;
  logic [CfgDataW-1:0]        cfg_data_i  = '0;
  logic                       in_valid_i  = 1'b0;
  logic                       in_ready_o;
  logic signed [MixW-1:0]     mix_left_i  = '0;
  logic signed [MixW-1:0]     mix_right_i = '0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  logic signed [SampleW-1:0]  out_left_o;
  logic signed [SampleW-1:0]  out_right_o;

  stereo_echo_mix_and_clip uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mix_left_i  (mix_left_i),
    .mix_right_i (mix_right_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_left_o  (out_left_o),
    .out_right_o (out_right_o)
  );

  // Predictor state: the delay line, its write position and the register copies.
  logic signed [SampleW-1:0] echo_mem [DelayDepth];
  addr_t                     wr_pos;
  logic                      cfg_echo_on;
  int                        cfg_delay;
  int                        cfg_gain_l;
  int                        cfg_gain_r;

  // Frames waiting to be sent and clipped frames waiting to come out.
  mix_frame_t  pending_frames[$];
  out_frame_t  expected_frames[$];
  int unsigned frames_queued   = 0;
  int unsigned frames_accepted = 0;
  int unsigned results_seen    = 0;
  int unsigned errors          = 0;
  int unsigned idle_cycles     = 0;

  // Idling controls set between phases.
  logic        send_idle = 1'b1;
  logic        recv_idle = 1'b1;
  logic        hold_req  = 1'b0;
  logic        hold_done = 1'b0;
  int unsigned gap_left  = 0;
  int unsigned hold_cnt  = 0;

  // Clock.
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 80);
  endfunction

  // Add the scaled delayed entry, clip both channels and feed their average back.
  function automatic out_frame_t predict_echo_frame(input logic signed [MixW-1:0] ml,
                                                    input logic signed [MixW-1:0] mr);
    out_frame_t res;
    longint     l;
    longint     r;
    longint     tap;
    longint     s;
    addr_t      rd_at;
    l = ml;
    r = mr;
    if (cfg_echo_on) begin
      rd_at = wr_pos - addr_t'(cfg_delay);
      tap = echo_mem[rd_at];
      // Signed division truncates toward zero, as the gain product requires.
      l += (tap * longint'(cfg_gain_l)) / GainScale;
      r += (tap * longint'(cfg_gain_r)) / GainScale;
    end
    if (l > SampleMax) l = SampleMax;
    if (l < SampleMin) l = SampleMin;
    if (r > SampleMax) r = SampleMax;
    if (r < SampleMin) r = SampleMin;
    if (cfg_echo_on) begin
      s = l + r;
      echo_mem[wr_pos] = SampleW'(s / 2);
      wr_pos = wr_pos + addr_t'(1);
    end
    res.left  = SampleW'(l);
    res.right = SampleW'(r);
    return res;
  endfunction

  // One line per mismatch, capped so that a broken block cannot flood the log.
  task automatic report_mismatch(input string what, input logic signed [SampleW-1:0] got,
                                 input logic signed [SampleW-1:0] want);
    errors++;
    if (errors <= PrintLimit)
      $display("MISMATCH %s on result %0d: got %0d, expected %0d",
               what, results_seen, got, want);
  endtask

  // Register write; the predictor copy masks the data to the register width.
  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      CFG_ECHO_ENABLE:  cfg_echo_on = data[0];
      CFG_DELAY_LENGTH: cfg_delay   = int'(data[DlyLenW-1:0]);
      CFG_LEFT_GAIN:    cfg_gain_l  = int'(data[GainW-1:0]);
      CFG_RIGHT_GAIN:   cfg_gain_r  = int'(data[GainW-1:0]);
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [CfgDataW-1:0] en, input logic [CfgDataW-1:0] dly,
                                input logic [CfgDataW-1:0] gl, input logic [CfgDataW-1:0] gr);
    write_reg(CFG_ECHO_ENABLE, en);
    write_reg(CFG_DELAY_LENGTH, dly);
    write_reg(CFG_LEFT_GAIN, gl);
    write_reg(CFG_RIGHT_GAIN, gr);
  endtask

  task automatic queue_frame(input int ml, input int mr);
    mix_frame_t f;
    f.left  = MixW'(ml);
    f.right = MixW'(mr);
    pending_frames.push_back(f);
    frames_queued++;
  endtask

  // Wait until every queued frame has been sent and every result has come back.
  task automatic drain();
    while (frames_accepted != frames_queued || expected_frames.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Mix values: mostly moderate, with clip boundaries, field extremes and raw bits.
  function automatic int rand_mix();
    int unsigned r;
    int          v;
    r = $urandom_range(0, 99);
    if (r < 15) return int'($signed(MixW'($urandom())));
    if (r < 30) begin
      v = $urandom_range(32752, 32783);
      return $urandom_range(0, 1) ? -v : v;
    end
    if (r < 40) begin
      case ($urandom_range(0, 3))
        0: return -1048576;
        1: return 1048575;
        2: return 0;
        default: return -1;
      endcase
    end
    return int'($urandom_range(0, 40000)) - 20000;
  endfunction

  function automatic logic [CfgDataW-1:0] pick_delay();
    case ($urandom_range(0, 7))
      0: return '0;
      1, 2, 3: return CfgDataW'($urandom_range(1, 8));
      4: return CfgDataW'($urandom_range(9, 300));
      5: return CfgDataW'($urandom());
      6: return CfgDataW'(LastAddr);
      default: return CfgDataW'($urandom_range(1, 3));
    endcase
  endfunction

  // Gain data carries random bits above the register width.
  function automatic logic [CfgDataW-1:0] pick_gain();
    case ($urandom_range(0, 5))
      0: return {2'($urandom()), 16'h0000};
      1: return {2'($urandom()), 16'hFFFF};
      default: return CfgDataW'($urandom());
    endcase
  endfunction

  // Driver: offers frames from the pending queue and predicts each accepted beat.
  always @(posedge clk_i or negedge rst_ni) begin : driver
    mix_frame_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expected_frames.push_back(predict_echo_frame(mix_left_i, mix_right_i));
        frames_accepted++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_frames.size() > 0) begin
          nxt = pending_frames.pop_front();
          in_valid_i  <= 1'b1;
          mix_left_i  <= nxt.left;
          mix_right_i <= nxt.right;
          gap_left = send_idle ? pick_gap() : 0;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result beat and paces the receiver's ready.
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    out_frame_t want;
    logic       next_rdy;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_cnt = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_frames.size() == 0) begin
          report_mismatch("unexpected result", out_left_o, '0);
        end else begin
          want = expected_frames.pop_front();
          if (out_left_o !== want.left) report_mismatch("out_left", out_left_o, want.left);
          if (out_right_o !== want.right)
            report_mismatch("out_right", out_right_o, want.right);
        end
        results_seen++;
      end
      // A requested long hold-off lets the block fill up and stall its input.
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_cnt  = LongHold;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        next_rdy = 1'b0;
      end else if (!recv_idle || $urandom_range(0, 99) < 70) begin
        next_rdy = 1'b1;
      end else begin
        next_rdy = 1'b0;
        hold_cnt = pick_gap();
      end
      out_ready_i <= next_rdy;
    end
  end

  // Watchdog: too many cycles without a beat on either side ends the run.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Stimulus: directed phases, then random settings with random frames.
  initial begin
    for (int i = 0; i < DelayDepth; i++) echo_mem[i] = '0;
    wr_pos      = '0;
    cfg_echo_on = 1'b0;
    cfg_delay   = int'(DelayLenReset);
    cfg_gain_l  = int'(GainReset);
    cfg_gain_r  = int'(GainReset);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Echo off with reset gains and delay; the enable write has its upper bits set.
    write_reg(CFG_ECHO_ENABLE, 18'h3FFFE);
    queue_frame(1048575, -1048576);
    queue_frame(-1048576, 1048575);
    queue_frame(32767, -32768);
    queue_frame(32768, -32769);
    queue_frame(0, -1);
    queue_frame(12345, -23456);
    drain();

    // Delay of one frame at full gain: the entry read is the one just written.
    apply_settings(18'h20001, 18'd1, 18'h3FFFF, 18'h3FFFF);
    queue_frame(32767, 32767);
    queue_frame(32767, 32767);
    queue_frame(-32768, -32768);
    queue_frame(-32768, -32768);
    queue_frame(1000, -3000);
    queue_frame(0, 0);
    queue_frame(0, 0);
    queue_frame(-1, -1);
    drain();

    // Zero delay reads the current write position before it is overwritten.
    apply_settings(18'd1, 18'd0, 18'h08000, 18'h08000);
    queue_frame(20000, 20000);
    queue_frame(0, 0);
    queue_frame(-20000, 5000);
    queue_frame(0, 0);
    drain();

    // Longest delay, left gain masked to zero, right gain at its maximum.
    apply_settings(18'd1, 18'(LastAddr), 18'h10000, 18'h0FFFF);
    queue_frame(30000, -30000);
    queue_frame(-1048576, 1048575);
    queue_frame(5, -5);
    queue_frame(0, 0);
    drain();

    // Random phases; some run without idling, one holds the receiver off for long.
    for (int p = 0; p < RandPhases; p++) begin
      send_idle = !(p == 1 || p == 4 || p == 7);
      recv_idle = !(p == 1 || p == 7);
      apply_settings({17'($urandom()), 1'($urandom_range(0, 9) != 0)},
                     pick_delay(), pick_gain(), pick_gain());
      if (p == 4) hold_req = 1'b1;
      for (int k = 0; k < PhaseFrames; k++) queue_frame(rand_mix(), rand_mix());
      drain();
    end

    repeat (10) @(posedge clk_i);
    if (errors == 0 && expected_frames.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/sem_pkg.sv
design/sem_echo_ram.sv
design/sem_mix_clip.sv
design/stereo_echo_mix_and_clip.sv
verif/tb_stereo_echo_mix_and_clip.sv
